FILE: rtl/core/gls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gls_pkg
// Field widths, command codes and the result line type of the greedy list
// scheduler.
// ----------------------------------------------------------------------------
package gls_pkg;

  localparam int FUNC_W = 1;
  localparam int TIME_W = 16;
  localparam int IDX_W  = 3;
  localparam int CYC_W  = 32;
  localparam int CFG_W  = 4;

  localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]  processor_index;
    logic [TIME_W-1:0] remaining_time;
    logic [CYC_W-1:0]  cycle_number;
    logic              all_done;
    logic              last;
  } res_t;

endpackage

FILE: rtl/core/gls_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gls_cmd_if
// Command channel: load a job duration or advance one tick.
// ----------------------------------------------------------------------------
interface gls_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [gls_pkg::FUNC_W-1:0]  func;
  logic [gls_pkg::TIME_W-1:0]  job_time;

  modport source (output valid, output func, output job_time, input ready);
  modport sink   (input valid, input func, input job_time, output ready);
endinterface

FILE: rtl/core/gls_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gls_res_if
// Result channel: one snapshot line per processor in use.
// ----------------------------------------------------------------------------
interface gls_res_if;
  logic                        valid;
  logic                        ready;
  logic [gls_pkg::IDX_W-1:0]   processor_index;
  logic [gls_pkg::TIME_W-1:0]  remaining_time;
  logic [gls_pkg::CYC_W-1:0]   cycle_number;
  logic                        all_done;
  logic                        last;

  modport source (output valid, output processor_index, output remaining_time,
                  output cycle_number, output all_done, output last, input ready);
  modport sink   (input valid, input processor_index, input remaining_time,
                  input cycle_number, input all_done, input last, output ready);
endinterface

FILE: rtl/core/gls_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gls_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/gls_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gls_out_stage
// Output register for snapshot lines; free when empty or being drained.
// ----------------------------------------------------------------------------
module gls_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  gls_pkg::res_t   data,
  output logic            free,
  gls_res_if.source       res
);

  logic          valid;
  gls_pkg::res_t data_r;

  assign free = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
    end
  end

  assign res.valid           = valid;
  assign res.processor_index = data_r.processor_index;
  assign res.remaining_time  = data_r.remaining_time;
  assign res.cycle_number    = data_r.cycle_number;
  assign res.all_done        = data_r.all_done;
  assign res.last            = data_r.last;

endmodule

FILE: rtl/core/gls_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gls_ctrl
// Sequencer: takes loads into the processor and queue RAMs, and walks the
// processor RAM once per tick with a read and report per entry and a write-back where an entry changes.
// ----------------------------------------------------------------------------
module gls_ctrl #(
  parameter int MAX_PROCS  = 8,
  parameter int MAX_QUEUED = 64,
  localparam int PAW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  localparam int PCW = $clog2(MAX_PROCS + 1),
  localparam int QAW = (MAX_QUEUED > 1) ? $clog2(MAX_QUEUED) : 1,
  localparam int QCW = $clog2(MAX_QUEUED + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gls_pkg::CFG_W-1:0]   cfg_wdata,
  gls_cmd_if.sink                     cmd,
  // processor time RAM
  output logic                        p_we,
  output logic [PAW-1:0]              p_waddr,
  output logic [gls_pkg::TIME_W-1:0]  p_wdata,
  output logic [PAW-1:0]              p_raddr,
  input  logic [gls_pkg::TIME_W-1:0]  p_rdata,
  // job queue RAM
  output logic                        q_we,
  output logic [QAW-1:0]              q_waddr,
  output logic [gls_pkg::TIME_W-1:0]  q_wdata,
  output logic [QAW-1:0]              q_raddr,
  input  logic [gls_pkg::TIME_W-1:0]  q_rdata,
  // output stage
  output logic                        out_load,
  output gls_pkg::res_t               out_data,
  input  logic                        out_free
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                     state;
  logic [PAW-1:0]             idx;
  logic [MAX_PROCS-1:0]       busy;      // entry non-zero; clear means reads as zero
  logic [PCW-1:0]             proc_fill;
  logic [QCW-1:0]             queue_len;
  logic [QCW-1:0]             queue_head;
  logic [gls_pkg::CYC_W-1:0]  tick_count;
  logic                       started;
  logic [gls_pkg::CFG_W-1:0]  nproc;
  logic                       done_r;
  logic                       assign_r;

  logic [PCW-1:0]             m;
  logic                       cmd_xfer;
  logic                       is_load;
  logic                       waiting;
  logic                       any_idle;
  logic                       all_idle;
  logic [gls_pkg::TIME_W-1:0] cur;
  logic [gls_pkg::TIME_W-1:0] new_val;
  logic                       last_line;
  logic                       emit_go;
  logic                       load_proc;
  logic                       load_queue;
  logic                       give_job;
  logic                       count_down;

  // processors in use, clamped to 1..MAX_PROCS
  always_comb begin
    if (nproc == '0) begin
      m = PCW'(1);
    end else if (32'(nproc) > MAX_PROCS) begin
      m = PCW'(MAX_PROCS);
    end else begin
      m = PCW'(nproc);
    end
  end

  always_comb begin
    any_idle = 1'b0;
    all_idle = 1'b1;
    for (int i = 0; i < MAX_PROCS; i++) begin
      if (PCW'(i) < m) begin
        if (busy[i]) begin
          all_idle = 1'b0;
        end else begin
          any_idle = 1'b1;
        end
      end
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign is_load   = (cmd.func == gls_pkg::FUNC_LOAD);
  assign waiting   = queue_head < queue_len;

  assign cur       = busy[idx] ? p_rdata : '0;
  assign last_line = (PCW'(idx) + PCW'(1)) == m;
  assign emit_go   = (state == S_EMIT) && out_free;

  assign load_proc  = cmd_xfer && is_load && !started && (proc_fill < m);
  assign load_queue = cmd_xfer && is_load && !started && !(proc_fill < m) &&
                      (queue_len < QCW'(MAX_QUEUED));
  assign give_job   = emit_go && !done_r && assign_r && !busy[idx] && waiting;
  assign count_down = emit_go && !done_r && !assign_r && busy[idx];
  assign new_val    = give_job ? q_rdata : cur - gls_pkg::TIME_W'(1);

  assign p_we    = load_proc || give_job || count_down;
  assign p_waddr = load_proc ? proc_fill[PAW-1:0] : idx;
  assign p_wdata = load_proc ? cmd.job_time : new_val;
  assign p_raddr = idx;

  // head is stable for the read cycle ahead of each report
  assign q_we    = load_queue;
  assign q_waddr = queue_len[QAW-1:0];
  assign q_wdata = cmd.job_time;
  assign q_raddr = queue_head[QAW-1:0];

  assign out_load                 = emit_go;
  assign out_data.processor_index = gls_pkg::IDX_W'(idx);
  assign out_data.remaining_time  = cur;
  assign out_data.cycle_number    = tick_count;
  assign out_data.all_done        = done_r;
  assign out_data.last            = last_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      busy       <= '0;
      proc_fill  <= '0;
      queue_len  <= '0;
      queue_head <= '0;
      tick_count <= gls_pkg::CYC_W'(1);
      started    <= 1'b0;
      nproc      <= gls_pkg::CFG_W'(1);
      done_r     <= 1'b0;
      assign_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        nproc <= cfg_wdata;
      end
      if (load_proc) begin
        busy[proc_fill[PAW-1:0]] <= (cmd.job_time != '0);
        proc_fill                <= proc_fill + PCW'(1);
      end
      if (load_queue) begin
        queue_len <= queue_len + QCW'(1);
      end
      if (give_job) begin
        busy[idx]  <= (q_rdata != '0);
        queue_head <= queue_head + QCW'(1);
      end
      if (count_down) begin
        busy[idx] <= (new_val != '0);
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_xfer && !is_load) begin
            started  <= 1'b1;
            done_r   <= all_idle && !waiting;
            assign_r <= any_idle && waiting;
            idx      <= '0;
            state    <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            if (last_line) begin
              if (!done_r) begin
                tick_count <= tick_count + gls_pkg::CYC_W'(1);
              end
              state <= S_IDLE;
            end else begin
              idx   <= idx + PAW'(1);
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/greedy_list_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_list_scheduler_unit
// Greedy list scheduler: job loads, then per-tick processor snapshots.
// ----------------------------------------------------------------------------
// A load transfer gives no result. A tick transfer walks the m processors in
// use, one line each, and stalls while the result side holds off: the
// processor time RAM has one port pair and a registered read, so each
// processor line has a read state and then a report-and-write-back state.
// The input is not taken again until the last line of a tick has gone into
// the output register. Processor idle flags live in flip-flops, so no
// clearing pass is needed after reset.
module greedy_list_scheduler_unit #(
  parameter int MAX_PROCS  = 8,
  parameter int MAX_QUEUED = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [gls_pkg::CFG_W-1:0]  cfg_wdata,
  gls_cmd_if.sink                    cmd,
  gls_res_if.source                  res
);

  localparam int PAW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int QAW = (MAX_QUEUED > 1) ? $clog2(MAX_QUEUED) : 1;

  logic                        p_we;
  logic [PAW-1:0]              p_waddr;
  logic [gls_pkg::TIME_W-1:0]  p_wdata;
  logic [PAW-1:0]              p_raddr;
  logic [gls_pkg::TIME_W-1:0]  p_rdata;
  logic                        q_we;
  logic [QAW-1:0]              q_waddr;
  logic [gls_pkg::TIME_W-1:0]  q_wdata;
  logic [QAW-1:0]              q_raddr;
  logic [gls_pkg::TIME_W-1:0]  q_rdata;
  logic                        out_load;
  gls_pkg::res_t               out_data;
  logic                        out_free;

  gls_ram #(
    .WIDTH (gls_pkg::TIME_W),
    .DEPTH (MAX_PROCS)
  ) u_proc_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  gls_ram #(
    .WIDTH (gls_pkg::TIME_W),
    .DEPTH (MAX_QUEUED)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  gls_ctrl #(
    .MAX_PROCS  (MAX_PROCS),
    .MAX_QUEUED (MAX_QUEUED)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .p_we      (p_we),
    .p_waddr   (p_waddr),
    .p_wdata   (p_wdata),
    .p_raddr   (p_raddr),
    .p_rdata   (p_rdata),
    .q_we      (q_we),
    .q_waddr   (q_waddr),
    .q_wdata   (q_wdata),
    .q_raddr   (q_raddr),
    .q_rdata   (q_rdata),
    .out_load  (out_load),
    .out_data  (out_data),
    .out_free  (out_free)
  );

  gls_out_stage u_out_stage (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .data (out_data),
    .free (out_free),
    .res  (res)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks greedy_list_scheduler_unit against a cycle-free model of the
// schedule. The model is held in a scoreboard class and produces the snapshot
// lines of every tick. The stimulus loads a full job list, including loads
// past the queue's capacity, then runs ticks under a range of processor
// counts, with loads after the start as noise. Both sides of the handshake
// idle at random, and the result side once holds off long enough to back
// the block up.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PROCS_MAX     = 8;
  localparam int QUEUE_DEPTH   = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 3000;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [gls_pkg::CFG_W-1:0] cfg_wdata;

  gls_cmd_if cmd_ch ();
  gls_res_if res_ch ();

  // Schedule model and the snapshot lines still owed by the block
  class schedule_board;
    logic [gls_pkg::TIME_W-1:0] proc_left [PROCS_MAX];
    logic [gls_pkg::TIME_W-1:0] job_fifo [QUEUE_DEPTH];
    int unsigned                jobs_loaded;
    int unsigned                jobs_queued;
    int unsigned                fifo_head;
    logic [gls_pkg::CYC_W-1:0]  cycle;
    bit                         running;
    logic [gls_pkg::CFG_W-1:0]  procs_cfg;
    gls_pkg::res_t              expected_lines[$];
    int unsigned                failures;

    function new();
      foreach (proc_left[i]) proc_left[i] = '0;
      foreach (job_fifo[i]) job_fifo[i] = '0;
      jobs_loaded = 0;
      jobs_queued = 0;
      fifo_head   = 0;
      cycle       = gls_pkg::CYC_W'(1);
      running     = 1'b0;
      procs_cfg   = gls_pkg::CFG_W'(1);
      failures    = 0;
    endfunction

    function void set_procs(logic [gls_pkg::CFG_W-1:0] v);
      procs_cfg = v;
    endfunction

    function int unsigned procs_used();
      int unsigned m;
      m = 32'(procs_cfg);
      if (m == 0) m = 1;
      if (m > PROCS_MAX) m = PROCS_MAX;
      return m;
    endfunction

    function void note_cmd(logic [gls_pkg::FUNC_W-1:0] f, logic [gls_pkg::TIME_W-1:0] t);
      int unsigned   m;
      int unsigned   on_procs;
      bit            waiting;
      bit            any_idle;
      bit            all_idle;
      bit            done;
      gls_pkg::res_t line;
      m = procs_used();
      if (f == gls_pkg::FUNC_LOAD) begin
        if (running) return;
        on_procs = jobs_loaded - jobs_queued;
        if (on_procs < m) begin
          proc_left[on_procs] = t;
          jobs_loaded++;
        end else if (jobs_queued < QUEUE_DEPTH) begin
          job_fifo[jobs_queued] = t;
          jobs_queued++;
          jobs_loaded++;
        end
        return;
      end
      running  = 1'b1;
      waiting  = fifo_head < jobs_queued;
      any_idle = 1'b0;
      all_idle = 1'b1;
      for (int i = 0; i < m; i++) begin
        if (proc_left[i] == 0) any_idle = 1'b1;
        else all_idle = 1'b0;
      end
      done = all_idle && !waiting;
      for (int i = 0; i < m; i++) begin
        line.processor_index = gls_pkg::IDX_W'(i);
        line.remaining_time  = proc_left[i];
        line.cycle_number    = cycle;
        line.all_done        = done;
        line.last            = (i + 1 == m);
        expected_lines.push_back(line);
      end
      if (!done) begin
        // a tick that hands out jobs does not count anything down
        if (any_idle && waiting) begin
          for (int i = 0; i < m; i++) begin
            if (proc_left[i] == 0 && fifo_head < jobs_queued) begin
              proc_left[i] = job_fifo[fifo_head];
              fifo_head++;
            end
          end
        end else begin
          for (int i = 0; i < m; i++) begin
            if (proc_left[i] > 0) proc_left[i] = proc_left[i] - 1'b1;
          end
        end
        cycle = cycle + 1'b1;
      end
    endfunction

    function void check_line(gls_pkg::res_t got);
      gls_pkg::res_t want;
      if (expected_lines.size() == 0) begin
        $error("unexpected result line: processor_index %0d cycle_number %0d",
               got.processor_index, got.cycle_number);
        failures++;
        return;
      end
      want = expected_lines.pop_front();
      if (got.processor_index !== want.processor_index) begin
        $error("processor_index: expected %0d, got %0d",
               want.processor_index, got.processor_index);
        failures++;
      end
      if (got.remaining_time !== want.remaining_time) begin
        $error("remaining_time: expected %0d, got %0d",
               want.remaining_time, got.remaining_time);
        failures++;
      end
      if (got.cycle_number !== want.cycle_number) begin
        $error("cycle_number: expected %0d, got %0d",
               want.cycle_number, got.cycle_number);
        failures++;
      end
      if (got.all_done !== want.all_done) begin
        $error("all_done: expected %0b, got %0b", want.all_done, got.all_done);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  schedule_board board;
  bit            calm;
  bit            hold_req;

  greedy_list_scheduler_unit #(
    .MAX_PROCS  (PROCS_MAX),
    .MAX_QUEUED (QUEUE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic send_cmd(input logic [gls_pkg::FUNC_W-1:0] f,
                          input logic [gls_pkg::TIME_W-1:0] t);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid    = 1'b1;
    cmd_ch.func     = f;
    cmd_ch.job_time = t;
    do @(posedge clk); while (!cmd_ch.ready);
    board.note_cmd(f, t);
  endtask

  // Stop offering, let every owed line arrive, then allow for a load in flight
  task automatic wait_drained();
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (board.expected_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_procs(input logic [gls_pkg::CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_procs(v);
  endtask

  // Result side
  initial begin
    int unsigned   gap;
    gls_pkg::res_t got;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = draw_gap();
      end
      if (gap > 0) begin
        res_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got.processor_index = res_ch.processor_index;
      got.remaining_time  = res_ch.remaining_time;
      got.cycle_number    = res_ch.cycle_number;
      got.all_done        = res_ch.all_done;
      got.last            = res_ch.last;
      board.check_line(got);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    logic [gls_pkg::CFG_W-1:0] phase_cfg [6];
    int unsigned               phase_ticks [6];
    int unsigned               n;
    board           = new();
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.func     = gls_pkg::FUNC_LOAD;
    cmd_ch.job_time = '0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Processors: a zero-length job, short jobs, and long ones on the upper
    // slots, which are later frozen by lowering the processor count
    write_procs(4'd8);
    send_cmd(gls_pkg::FUNC_LOAD, 16'd0);
    send_cmd(gls_pkg::FUNC_LOAD, 16'd1);
    send_cmd(gls_pkg::FUNC_LOAD, 16'd2);
    send_cmd(gls_pkg::FUNC_LOAD, 16'd3);
    send_cmd(gls_pkg::FUNC_LOAD, 16'hFFFF);
    send_cmd(gls_pkg::FUNC_LOAD, 16'hAAAA);
    send_cmd(gls_pkg::FUNC_LOAD, 16'h5555);
    send_cmd(gls_pkg::FUNC_LOAD, 16'hFFFE);

    // Fill the queue with short jobs; the loads beyond it must be dropped
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_cmd(gls_pkg::FUNC_LOAD, gls_pkg::TIME_W'($urandom_range(0, 2)));
    end
    repeat (5) send_cmd(gls_pkg::FUNC_LOAD, 16'hFFFF);

    // Count of zero reads as one: processor 0 idle with jobs waiting
    wait_drained();
    write_procs(4'd0);
    repeat (3) send_cmd(gls_pkg::FUNC_TICK, gls_pkg::TIME_W'($urandom));
    send_cmd(gls_pkg::FUNC_LOAD, 16'd1);

    // Count above the maximum reads as the maximum
    wait_drained();
    write_procs(4'd15);
    repeat (3) send_cmd(gls_pkg::FUNC_TICK, gls_pkg::TIME_W'($urandom));

    // Ends on small counts so the queue drains and the schedule finishes
    phase_cfg   = '{4'd4, 4'd8, 4'd5, 4'd1, 4'd3, 4'd2};
    phase_ticks = '{24, 8, 12, 6, 14, 14};
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_procs(phase_cfg[p]);
      calm = (p % 3 == 1);
      if (phase_cfg[p] == 4'd8) hold_req = 1'b1;
      n = 0;
      while (n < phase_ticks[p]) begin
        if ($urandom_range(0, 9) == 0) begin
          send_cmd(gls_pkg::FUNC_LOAD, gls_pkg::TIME_W'($urandom));
        end else begin
          send_cmd(gls_pkg::FUNC_TICK, gls_pkg::TIME_W'($urandom));
          n++;
        end
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
    end

    wait_drained();
    if (board.failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
